// ===== hw/rtl/jas_pkg.sv =====
// ----------------------------------------------------------------------------
// jas_pkg - shared types and constants of the joystick auto-calibrating scaler
// Register widths, reset values, register indexes and controller commands.
// ----------------------------------------------------------------------------
package jas_pkg;

	// default parameter values
	localparam int OUTPUT_SCALE_DEF = 32;
	localparam int SAMPLE_BITS_DEF  = 12;

	// field widths
	localparam int CAL_W      = 11;
	localparam int CNT_W      = 10;
	localparam int SETTLE_W   = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	// register reset values
	localparam logic [CAL_W-1:0]    ADAPT_LO_RST = CAL_W'(16 * 16);
	localparam logic [CAL_W-1:0]    ADAPT_HI_RST = CAL_W'(96 * 16);
	localparam logic [SETTLE_W-1:0] SETTLE_RST   = SETTLE_W'(32);
	localparam logic [CNT_W-1:0]    DECAY_RST    = CNT_W'(600);

	// dead band is word/32, growth is a quarter of the excess
	localparam int BAND_SHIFT = 5;
	localparam int GROW_SHIFT = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FREEZE   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ADAPT_LO = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_ADAPT_HI = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE   = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_DECAY    = CFG_IDX_W'(4);

	// input command codes
	localparam logic CMD_SAMPLE  = 1'b0;
	localparam logic CMD_RESTORE = 1'b1;

	typedef struct packed {
		logic                freeze;
		logic [CAL_W-1:0]    adapt_lo;
		logic [CAL_W-1:0]    adapt_hi;
		logic [SETTLE_W-1:0] settle;
		logic [CNT_W-1:0]    decay;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic eval;
		logic adapt;
		logic div_load;
		logic div_step;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [CAL_W-1:0] cal;
		logic [CNT_W-1:0] cnt;
	} adapt_t;

endpackage

// ===== hw/rtl/jas_div.sv =====
// ----------------------------------------------------------------------------
// jas_div - restoring divider with an overflow flag
// Produces a quotient one bit per step; the top bit flags a quotient that
// exceeds the scaled output range.
// ----------------------------------------------------------------------------
module jas_div
	import jas_pkg::*;
#(
	parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
	parameter int OUTPUT_SCALE = OUTPUT_SCALE_DEF
) (
	input  logic                                 clk,
	input  logic                                 load,
	input  logic                                 step,
	input  logic [SAMPLE_BITS+$clog2(OUTPUT_SCALE+1)-1:0] num,
	input  logic [CAL_W-1:0]                     den,
	output logic [$clog2(OUTPUT_SCALE+1):0]      quo
);

	localparam int Q_W   = $clog2(OUTPUT_SCALE + 1);
	localparam int NUM_W = SAMPLE_BITS + Q_W;
	localparam int DW    = (NUM_W > CAL_W + Q_W) ? NUM_W : CAL_W + Q_W;

	logic [DW-1:0]  rem_q;
	logic [DW-1:0]  den_q;
	logic [Q_W:0]   quo_q;
	logic           fits;

	assign fits = rem_q >= den_q;

	// shift-subtract, divisor walks down from den << Q_W
	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= DW'(num);
			den_q <= DW'(den) << Q_W;
			quo_q <= '0;
		end else if (step) begin
			if (fits) begin
				rem_q <= rem_q - den_q;
			end
			den_q <= den_q >> 1;
			quo_q <= {quo_q[Q_W-1:0], fits};
		end
	end

	assign quo = quo_q;

endmodule

// ===== hw/rtl/jas_dp.sv =====
// ----------------------------------------------------------------------------
// jas_dp - datapath of the joystick auto-calibrating scaler
// Holds the sample, calibration words and decay counters, adapts them and
// scales both axes through two dividers.
// ----------------------------------------------------------------------------
module jas_dp
	import jas_pkg::*;
#(
	parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
	parameter int OUTPUT_SCALE = OUTPUT_SCALE_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  ctrl_cmd_t                             cmd,
	input  cfg_t                                  cfg,
	input  logic                                  in_command,
	input  logic signed [SAMPLE_BITS-1:0]         in_x,
	input  logic signed [SAMPLE_BITS-1:0]         in_y,
	output logic signed [$clog2(OUTPUT_SCALE+1):0] x_scaled,
	output logic signed [$clog2(OUTPUT_SCALE+1):0] y_scaled,
	output logic                                  steady,
	output logic [3:0][CAL_W-1:0]                 cal_words
);

	localparam int SB     = SAMPLE_BITS;
	localparam int Q_W    = $clog2(OUTPUT_SCALE + 1);
	localparam int OUT_W  = Q_W + 1;
	localparam int NUM_W  = SB + Q_W;
	localparam int CMP_W  = (SB > CAL_W) ? SB : CAL_W;
	localparam int DLT_W  = SB + 2;
	localparam int DCMP_W = (DLT_W > SETTLE_W) ? DLT_W : SETTLE_W;
	localparam logic [Q_W-1:0] SCALE_MAX = Q_W'(OUTPUT_SCALE);

	function automatic logic [SB-1:0] mag_of(input logic [SB-1:0] v);
		return v[SB-1] ? (~v + 1'b1) : v;
	endfunction

	function automatic logic [SB:0] absd(input logic [SB:0] v);
		return v[SB] ? (~v + 1'b1) : v;
	endfunction

	// one half-axis update: grow beyond the dead band or count toward a shrink
	function automatic adapt_t adapt_half(
		input logic [CAL_W-1:0] c,
		input logic [CNT_W-1:0] n,
		input logic [CMP_W-1:0] mag,
		input logic             major,
		input cfg_t             cf
	);
		adapt_t           r;
		logic [CAL_W-1:0] band;
		logic [CMP_W-1:0] diff;
		logic [CMP_W-1:0] grow;
		logic [CNT_W-1:0] n1;
		r.cal = c;
		r.cnt = n;
		band  = c >> BAND_SHIFT;
		diff  = mag - CMP_W'(c);
		grow  = (diff - CMP_W'(band)) >> GROW_SHIFT;
		n1    = n + 1'b1;
		if (mag >= CMP_W'(cf.adapt_lo) && mag <= CMP_W'(cf.adapt_hi)) begin
			if (mag > CMP_W'(c)) begin
				r.cnt = '0;
				if (diff >= CMP_W'(band)) begin
					if (grow == '0) begin
						grow = CMP_W'(1);
					end
					r.cal = c + CAL_W'(grow);
				end
			end else if (major) begin
				if (n1 >= cf.decay) begin
					r.cal = c - band;
					r.cnt = '0;
				end else begin
					r.cnt = n1;
				end
			end
		end
		return r;
	endfunction

	// final scaled value from divider quotient
	function automatic logic [OUT_W-1:0] finish(
		input logic [SB-1:0]    mag,
		input logic [CAL_W-1:0] cal,
		input logic [Q_W:0]     q,
		input logic             neg
	);
		logic [Q_W-1:0] mv;
		if (mag == '0) begin
			mv = '0;
		end else if (cal == '0 || q[Q_W] || q[Q_W-1:0] > SCALE_MAX) begin
			mv = SCALE_MAX;
		end else begin
			mv = q[Q_W-1:0];
		end
		return neg ? (OUT_W'(0) - {1'b0, mv}) : {1'b0, mv};
	endfunction

	logic                    cmd_q;
	logic signed [SB-1:0]    x_q;
	logic signed [SB-1:0]    y_q;
	logic signed [SB-1:0]    last_x_q;
	logic signed [SB-1:0]    last_y_q;
	logic [SB-1:0]           xa_s1;
	logic [SB-1:0]           ya_s1;
	logic                    steady_s1;
	logic                    xmaj_s1;
	logic                    ymaj_s1;
	logic [3:0][CAL_W-1:0]   cal_q;
	logic [3:0][CNT_W-1:0]   cnt_q;

	logic [SB:0]             dx;
	logic [SB:0]             dy;
	logic [DLT_W-1:0]        delta;
	logic                    x_neg;
	logic                    y_neg;
	logic                    x_nz;
	logic                    y_nz;
	logic [CAL_W-1:0]        xc;
	logic [CAL_W-1:0]        yc;
	logic [CNT_W-1:0]        xn;
	logic [CNT_W-1:0]        yn;
	adapt_t                  xr;
	adapt_t                  yr;
	logic                    upd;
	logic [3:0]              wr;
	logic [NUM_W-1:0]        num_x;
	logic [NUM_W-1:0]        num_y;
	logic [Q_W:0]            quo_x;
	logic [Q_W:0]            quo_y;

	// sample capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= in_command;
			x_q   <= in_x;
			y_q   <= in_y;
		end
	end

	// motion measure against the previous sample
	assign dx    = {x_q[SB-1], x_q} - {last_x_q[SB-1], last_x_q};
	assign dy    = {y_q[SB-1], y_q} - {last_y_q[SB-1], last_y_q};
	assign delta = DLT_W'(absd(dx)) + DLT_W'(absd(dy));

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			xa_s1     <= mag_of(x_q);
			ya_s1     <= mag_of(y_q);
			xmaj_s1   <= mag_of(x_q) > mag_of(y_q);
			ymaj_s1   <= mag_of(y_q) > mag_of(x_q);
			steady_s1 <= (cmd_q == CMD_SAMPLE) &&
				(DCMP_W'(delta) < DCMP_W'(cfg.settle));
		end
	end

	// previous sample, kept across a restore command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q <= '0;
			last_y_q <= '0;
		end else if (cmd.eval && cmd_q == CMD_SAMPLE) begin
			last_x_q <= x_q;
			last_y_q <= y_q;
		end
	end

	// active half-axis per axis: X+ X- Y+ Y-
	assign x_neg = x_q[SB-1];
	assign y_neg = y_q[SB-1];
	assign x_nz  = x_q != '0;
	assign y_nz  = y_q != '0;
	assign xc    = x_neg ? cal_q[1] : cal_q[0];
	assign yc    = y_neg ? cal_q[3] : cal_q[2];
	assign xn    = x_neg ? cnt_q[1] : cnt_q[0];
	assign yn    = y_neg ? cnt_q[3] : cnt_q[2];
	assign xr    = adapt_half(xc, xn, CMP_W'(xa_s1), xmaj_s1, cfg);
	assign yr    = adapt_half(yc, yn, CMP_W'(ya_s1), ymaj_s1, cfg);
	assign upd   = cmd.adapt && cmd_q == CMD_SAMPLE && steady_s1 && !cfg.freeze;
	assign wr[0] = upd && x_nz && !x_neg;
	assign wr[1] = upd && x_nz && x_neg;
	assign wr[2] = upd && y_nz && !y_neg;
	assign wr[3] = upd && y_nz && y_neg;

	// calibration words and decay counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				cal_q[i] <= ADAPT_LO_RST;
				cnt_q[i] <= '0;
			end
		end else if (cmd.adapt && cmd_q == CMD_RESTORE) begin
			for (int i = 0; i < 4; i++) begin
				cal_q[i] <= cfg.adapt_lo;
				cnt_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < 4; i++) begin
				if (wr[i]) begin
					cal_q[i] <= (i < 2) ? xr.cal : yr.cal;
					cnt_q[i] <= (i < 2) ? xr.cnt : yr.cnt;
				end
			end
		end
	end

	// rounded division numerators: mag*scale + cal/2
	assign num_x = NUM_W'(xa_s1) * NUM_W'(OUTPUT_SCALE) + NUM_W'(xc >> 1);
	assign num_y = NUM_W'(ya_s1) * NUM_W'(OUTPUT_SCALE) + NUM_W'(yc >> 1);

	jas_div #(
		.SAMPLE_BITS  (SAMPLE_BITS),
		.OUTPUT_SCALE (OUTPUT_SCALE)
	) u_div_x (
		.clk  (clk),
		.load (cmd.div_load),
		.step (cmd.div_step),
		.num  (num_x),
		.den  (xc),
		.quo  (quo_x)
	);

	jas_div #(
		.SAMPLE_BITS  (SAMPLE_BITS),
		.OUTPUT_SCALE (OUTPUT_SCALE)
	) u_div_y (
		.clk  (clk),
		.load (cmd.div_load),
		.step (cmd.div_step),
		.num  (num_y),
		.den  (yc),
		.quo  (quo_y)
	);

	// result, zeroed for a restore command
	assign x_scaled  = (cmd_q == CMD_RESTORE) ? '0 : $signed(finish(xa_s1, xc, quo_x, x_neg));
	assign y_scaled  = (cmd_q == CMD_RESTORE) ? '0 : $signed(finish(ya_s1, yc, quo_y, y_neg));
	assign steady    = steady_s1;
	assign cal_words = cal_q;

endmodule

// ===== hw/rtl/jas_ctrl.sv =====
// ----------------------------------------------------------------------------
// jas_ctrl - sequencer of the joystick auto-calibrating scaler
// Steps one item through evaluate, adapt, divide and result hand-off.
// ----------------------------------------------------------------------------
module jas_ctrl
	import jas_pkg::*;
#(
	parameter int OUTPUT_SCALE = OUTPUT_SCALE_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      out_free,
	output logic      in_ready,
	output ctrl_cmd_t cmd
);

	localparam int Q_W   = $clog2(OUTPUT_SCALE + 1);
	localparam int STP_W = $clog2(Q_W + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EVAL  = 3'd1;
	localparam logic [2:0] ST_ADAPT = 3'd2;
	localparam logic [2:0] ST_DLOAD = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0]       state_q;
	logic [2:0]       state_d;
	logic [STP_W-1:0] step_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = ST_ADAPT;
			end
			ST_ADAPT: begin
				cmd.adapt = 1'b1;
				state_d   = ST_DLOAD;
			end
			ST_DLOAD: begin
				cmd.div_load = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == '0) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				cmd.out_load = out_free;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_ready = state_q == ST_IDLE;

	// state and divide step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.div_load) begin
				step_q <= STP_W'(Q_W);
			end else if (cmd.div_step) begin
				step_q <= step_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/joystick_autocal_scaler_top.sv =====
// ----------------------------------------------------------------------------
// joystick_autocal_scaler_top - auto-calibrating joystick scaler
// Scales signed X/Y stick samples to +-OUTPUT_SCALE with self-adapting
// half-axis full-scale words.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one item: a sample (s_tuser = 0) or a calibration
//   restore (s_tuser = 1). m_* channel gives one result item per input item:
//   both scaled axes, the steady flag and the four calibration words.
//   cfg_we/cfg_index/cfg_data write a register at the clock edge; write only
//   while no item is in flight.
//   An accepted item passes the evaluate, adapt, divider load, divide and
//   output states in turn; the two dividers give one quotient bit per cycle.
//   The next item is taken only once the sequencer is back in idle.
//   The result sits in an output register, so the next item is accepted
//   and worked on while m_tready is low; the block holds before writing
//   the register until the earlier result has been taken.
//   arst_n clears the sequencer and output valid and loads the register
//   defaults, calibration words of 256 and zero decay counters.
// ----------------------------------------------------------------------------
module joystick_autocal_scaler_top
	import jas_pkg::*;
#(
	parameter int OUTPUT_SCALE = OUTPUT_SCALE_DEF,
	parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input item channel
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// s_tdata: x_sample, y_sample, zero fill
	input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
	// s_tuser: command
	input  logic                  s_tuser,
	// result item channel
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// m_tdata: x_scaled, y_scaled, steady, cal_x_pos, cal_x_neg, cal_y_pos,
	// cal_y_neg, zero fill
	output logic [((2*($clog2(OUTPUT_SCALE+1)+1)+1+4*CAL_W+7)/8)*8-1:0] m_tdata
);

	localparam int OUT_W  = $clog2(OUTPUT_SCALE + 1) + 1;
	localparam int RES_W  = 2 * OUT_W + 1 + 4 * CAL_W;
	localparam int OUT_DW = ((RES_W + 7) / 8) * 8;

	cfg_t                    cfg_q;
	ctrl_cmd_t               cmd;
	logic                    out_free;
	logic                    out_valid_q;
	logic [OUT_DW-1:0]       out_data_q;
	logic signed [OUT_W-1:0] x_scaled;
	logic signed [OUT_W-1:0] y_scaled;
	logic                    steady;
	logic [3:0][CAL_W-1:0]   cal_words;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.freeze   <= 1'b0;
			cfg_q.adapt_lo <= ADAPT_LO_RST;
			cfg_q.adapt_hi <= ADAPT_HI_RST;
			cfg_q.settle   <= SETTLE_RST;
			cfg_q.decay    <= DECAY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FREEZE:   cfg_q.freeze   <= cfg_data[0];
				REG_ADAPT_LO: cfg_q.adapt_lo <= cfg_data[CAL_W-1:0];
				REG_ADAPT_HI: cfg_q.adapt_hi <= cfg_data[CAL_W-1:0];
				REG_SETTLE:   cfg_q.settle   <= cfg_data[SETTLE_W-1:0];
				REG_DECAY:    cfg_q.decay    <= cfg_data[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	jas_ctrl #(
		.OUTPUT_SCALE (OUTPUT_SCALE)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.out_free (out_free),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	jas_dp #(
		.SAMPLE_BITS  (SAMPLE_BITS),
		.OUTPUT_SCALE (OUTPUT_SCALE)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg        (cfg_q),
		.in_command (s_tuser),
		.in_x       (s_tdata[SAMPLE_BITS-1:0]),
		.in_y       (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
		.x_scaled   (x_scaled),
		.y_scaled   (y_scaled),
		.steady     (steady),
		.cal_words  (cal_words)
	);

	// output register, free when empty or being taken
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= OUT_DW'({cal_words[3], cal_words[2], cal_words[1], cal_words[0],
				steady, y_scaled, x_scaled});
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ===== dv/joystick_autocal_scaler_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_autocal_scaler_top_tb - self-checking bench of the stick scaler
// Drives sample and restore items through the stream input and predicts each
// result item: scaled X/Y, steady flag and the four calibration words. A
// directed part covers extremes and the special cases of adaptation and
// scaling. Random phases under several register settings then walk the stick
// in small steps with jumps, noise and restores, and stall both handshakes.
// ----------------------------------------------------------------------------
module joystick_autocal_scaler_top_tb
	import jas_pkg::*;
();

	localparam int FULL_SCALE  = OUTPUT_SCALE_DEF;
	localparam int SMP_W       = SAMPLE_BITS_DEF;
	localparam int SC_W        = $clog2(FULL_SCALE + 1) + 1;
	localparam int S_W         = ((2 * SMP_W + 7) / 8) * 8;
	localparam int M_W         = ((2 * SC_W + 1 + 4 * CAL_W + 7) / 8) * 8;
	localparam int Y_LSB       = SC_W;
	localparam int STEADY_BIT  = 2 * SC_W;
	localparam int CAL_LSB     = 2 * SC_W + 1;
	localparam int SMP_MAX     = (1 << (SMP_W - 1)) - 1;
	localparam int SMP_MIN     = -(1 << (SMP_W - 1));
	localparam int BAND_DIV    = 1 << BAND_SHIFT;
	localparam int GROW_DIV    = 1 << GROW_SHIFT;
	localparam int DRAIN_WAIT  = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PRINT_CAP   = 100;

	typedef enum int {
		HALF_XP = 0,
		HALF_XN = 1,
		HALF_YP = 2,
		HALF_YN = 3
	} half_axis_t;

	typedef struct packed {
		logic [SC_W-1:0]  x_scaled;
		logic [SC_W-1:0]  y_scaled;
		logic             steady;
		logic [CAL_W-1:0] cal_xp;
		logic [CAL_W-1:0] cal_xn;
		logic [CAL_W-1:0] cal_yp;
		logic [CAL_W-1:0] cal_yn;
	} joy_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	// s_tdata: x_sample, y_sample, zero fill
	logic [S_W-1:0]        s_tdata;
	// s_tuser: command
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	// m_tdata: x_scaled, y_scaled, steady, cal_x_pos, cal_x_neg, cal_y_pos,
	// cal_y_neg, zero fill
	logic [M_W-1:0]        m_tdata;

	// register copies of the predictor
	bit freeze_cfg;
	int adapt_lo_cfg;
	int adapt_hi_cfg;
	int settle_cfg;
	int decay_cfg;

	// calibration state of the predictor
	logic [CAL_W-1:0] cal_word [4];
	logic [CNT_W-1:0] quiet_count [4];
	int last_x;
	int last_y;

	// results predicted but not yet seen
	joy_result_t pending_scaled [$];

	// stimulus state and run statistics
	int  walk_x;
	int  walk_y;
	bit  send_no_gap;
	bit  take_no_stall;
	int  hold_req;
	int  errors;
	int  cycle_count;
	int  items_sent;
	int  restores_sent;
	int  results_seen;
	int  steady_results;
	int  grow_events;
	int  shrink_events;
	int  settings_used;

	joystick_autocal_scaler_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// clock
	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
				cycle_count, pending_scaled.size());
			$display("joystick_autocal_scaler_top test failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------

	function automatic int abs_int(input int v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic int clamp_sample(input int v);
		if (v > SMP_MAX)
			return SMP_MAX;
		if (v < SMP_MIN)
			return SMP_MIN;
		return v;
	endfunction

	// rounded division to full scale, zero word saturates
	function automatic int scale_mag(input int mag, input int cal);
		int v;
		if (mag == 0)
			return 0;
		if (cal == 0)
			return FULL_SCALE;
		v = (mag * FULL_SCALE + cal / 2) / cal;
		return (v > FULL_SCALE) ? FULL_SCALE : v;
	endfunction

	task automatic restore_words();
		for (int i = 0; i < 4; i++) begin
			cal_word[i]    = CAL_W'(adapt_lo_cfg);
			quiet_count[i] = '0;
		end
	endtask

	// grow past the dead band or count toward a shrink on the major axis
	task automatic adapt_half(input half_axis_t h, input int mag, input bit major);
		int c;
		int band;
		int diff;
		c = cal_word[h];
		band = c / BAND_DIV;
		if (mag < adapt_lo_cfg || mag > adapt_hi_cfg)
			return;
		if (mag > c) begin
			quiet_count[h] = '0;
			diff = mag - c;
			if (diff < band)
				return;
			diff = (diff - band) / GROW_DIV;
			if (diff == 0)
				diff = 1;
			cal_word[h] = CAL_W'(c + diff);
			grow_events++;
		end else if (major) begin
			quiet_count[h] = quiet_count[h] + 1'b1;
			if (int'(quiet_count[h]) >= decay_cfg) begin
				cal_word[h]    = CAL_W'(c - band);
				quiet_count[h] = '0;
				shrink_events++;
			end
		end
	endtask

	task automatic calibrate_and_scale(input logic cmd, input logic signed [SMP_W-1:0] xs,
		input logic signed [SMP_W-1:0] ys, output joy_result_t r);
		int x;
		int y;
		int xa;
		int ya;
		int xo;
		int yo;
		bit stdy;
		xo = 0;
		yo = 0;
		stdy = 1'b0;
		if (cmd == CMD_RESTORE) begin
			restore_words();
		end else begin
			x = xs;
			y = ys;
			xa = abs_int(x);
			ya = abs_int(y);
			stdy = (abs_int(x - last_x) + abs_int(y - last_y)) < settle_cfg;
			if (stdy && !freeze_cfg) begin
				if (x > 0) adapt_half(HALF_XP, xa, xa > ya);
				if (x < 0) adapt_half(HALF_XN, xa, xa > ya);
				if (y > 0) adapt_half(HALF_YP, ya, ya > xa);
				if (y < 0) adapt_half(HALF_YN, ya, ya > xa);
			end
			last_x = x;
			last_y = y;
			// scaling uses the words after adaptation
			if (x > 0) xo = scale_mag(xa, cal_word[HALF_XP]);
			if (x < 0) xo = -scale_mag(xa, cal_word[HALF_XN]);
			if (y > 0) yo = scale_mag(ya, cal_word[HALF_YP]);
			if (y < 0) yo = -scale_mag(ya, cal_word[HALF_YN]);
			if (stdy)
				steady_results++;
		end
		r.x_scaled = SC_W'(xo);
		r.y_scaled = SC_W'(yo);
		r.steady   = stdy;
		r.cal_xp   = cal_word[HALF_XP];
		r.cal_xn   = cal_word[HALF_XN];
		r.cal_yp   = cal_word[HALF_YP];
		r.cal_yn   = cal_word[HALF_YN];
	endtask

	// ------------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------------

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			errors++;
			if (errors <= PRINT_CAP)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	task automatic check_result(input logic [M_W-1:0] d);
		joy_result_t want;
		if (pending_scaled.size() == 0) begin
			errors++;
			$display("%0t: result item with none expected, expected none, actual %h", $time, d);
			return;
		end
		want = pending_scaled.pop_front();
		results_seen++;
		check_field("x_scaled", $signed(want.x_scaled), $signed(d[0 +: SC_W]));
		check_field("y_scaled", $signed(want.y_scaled), $signed(d[Y_LSB +: SC_W]));
		check_field("steady", want.steady, d[STEADY_BIT]);
		check_field("cal_x_pos", want.cal_xp, d[CAL_LSB +: CAL_W]);
		check_field("cal_x_neg", want.cal_xn, d[CAL_LSB + CAL_W +: CAL_W]);
		check_field("cal_y_pos", want.cal_yp, d[CAL_LSB + 2 * CAL_W +: CAL_W]);
		check_field("cal_y_neg", want.cal_yn, d[CAL_LSB + 3 * CAL_W +: CAL_W]);
	endtask

	// result side: random stalls, long hold on request
	initial begin : take_results
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req > 0) begin
				m_tready <= 1'b0;
				repeat (hold_req) @(posedge clk);
				hold_req = 0;
			end
			stall = take_no_stall ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			check_result(m_tdata);
		end
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------

	// offer one item after a random gap, predict it once taken
	task automatic send_item(input logic cmd, input logic signed [SMP_W-1:0] xs,
		input logic signed [SMP_W-1:0] ys);
		joy_result_t want;
		int gap;
		gap = send_no_gap ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= S_W'({ys, xs});
		do @(posedge clk); while (s_tready !== 1'b1);
		calibrate_and_scale(cmd, xs, ys, want);
		pending_scaled.push_back(want);
		items_sent++;
		if (cmd == CMD_RESTORE)
			restores_sent++;
	endtask

	// stop offering and let every outstanding result come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_scaled.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// write all five registers, block idle
	task automatic configure(input bit frz, input int mn, input int mx, input int st,
		input int dc);
		cfg_we    <= 1'b1;
		cfg_index <= REG_FREEZE;
		cfg_data  <= CFG_DATA_W'(frz);
		@(posedge clk);
		cfg_index <= REG_ADAPT_LO;
		cfg_data  <= CFG_DATA_W'(mn);
		@(posedge clk);
		cfg_index <= REG_ADAPT_HI;
		cfg_data  <= CFG_DATA_W'(mx);
		@(posedge clk);
		cfg_index <= REG_SETTLE;
		cfg_data  <= CFG_DATA_W'(st);
		@(posedge clk);
		cfg_index <= REG_DECAY;
		cfg_data  <= CFG_DATA_W'(dc);
		@(posedge clk);
		cfg_we    <= 1'b0;
		freeze_cfg   = frz;
		adapt_lo_cfg = mn & ((1 << CAL_W) - 1);
		adapt_hi_cfg = mx & ((1 << CAL_W) - 1);
		settle_cfg   = st & ((1 << SETTLE_W) - 1);
		decay_cfg    = dc & ((1 << CNT_W) - 1);
		settings_used++;
	endtask

	// new stick position around the adaptation window
	task automatic jump_walk();
		int lo;
		int hi;
		int big;
		int other;
		lo = adapt_lo_cfg - 16;
		hi = adapt_hi_cfg + 16;
		if (lo < 0) lo = 0;
		if (hi > SMP_MAX) hi = SMP_MAX;
		if (lo > hi) begin
			lo = 0;
			hi = SMP_MAX;
		end
		big = $urandom_range(hi, lo);
		case ($urandom_range(0, 9))
			0: begin
				other = big;
			end
			1: begin
				other = 0;
			end
			default: begin
				other = $urandom_range(big / 2, 0);
			end
		endcase
		if ($urandom_range(0, 1)) big = -big;
		if ($urandom_range(0, 1)) other = -other;
		if ($urandom_range(0, 1)) begin
			walk_x = big;
			walk_y = other;
		end else begin
			walk_x = other;
			walk_y = big;
		end
	endtask

	// mostly small steady steps, some jumps, noise and restores
	task automatic send_walk_item();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 3) begin
			send_item(CMD_RESTORE, SMP_W'($urandom), SMP_W'($urandom));
		end else if (pick < 10) begin
			send_item(CMD_SAMPLE, SMP_W'($urandom), SMP_W'($urandom));
		end else begin
			if (pick < 20) begin
				jump_walk();
			end else begin
				walk_x = clamp_sample(walk_x + int'($urandom_range(0, 6)) - 3);
				walk_y = clamp_sample(walk_y + int'($urandom_range(0, 6)) - 3);
			end
			send_item(CMD_SAMPLE, SMP_W'(walk_x), SMP_W'(walk_y));
		end
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// reset settings: extremes, growth, dead band, each half-axis, ties
	task automatic test_directed_cases();
		send_item(CMD_SAMPLE, 0, 0);
		send_item(CMD_SAMPLE, SMP_W'(SMP_MAX), 0);
		send_item(CMD_SAMPLE, SMP_W'(SMP_MIN), 0);
		send_item(CMD_SAMPLE, 0, SMP_W'(SMP_MAX));
		send_item(CMD_SAMPLE, 0, SMP_W'(SMP_MIN));
		send_item(CMD_SAMPLE, SMP_W'(SMP_MIN), SMP_W'(SMP_MIN));
		send_item(CMD_RESTORE, 12'h5a5, 12'ha5a);
		// growth by a quarter of the excess
		repeat (3) send_item(CMD_SAMPLE, 400, 0);
		// minimum step of one, then inside the dead band
		send_item(CMD_RESTORE, 0, 0);
		repeat (2) send_item(CMD_SAMPLE, 265, 3);
		send_item(CMD_SAMPLE, 259, 3);
		// negative half-axes
		repeat (2) send_item(CMD_SAMPLE, -400, -5);
		repeat (2) send_item(CMD_SAMPLE, 5, -400);
		repeat (2) send_item(CMD_SAMPLE, -5, 400);
		// tie, no major axis
		repeat (2) send_item(CMD_SAMPLE, 300, 300);
		// top of the window and just past it
		repeat (2) send_item(CMD_SAMPLE, 1536, 0);
		send_item(CMD_SAMPLE, 1537, 0);
	endtask

	// zero words, freeze, decay count zero, never steady, quick shrink
	task automatic test_register_extremes();
		wait_drained();
		configure(1'b1, 0, 2047, 4095, 0);
		send_item(CMD_RESTORE, 0, 0);
		send_item(CMD_SAMPLE, 100, 0);
		send_item(CMD_SAMPLE, -1, 0);
		send_item(CMD_SAMPLE, 0, -1);
		send_item(CMD_SAMPLE, 0, 0);
		wait_drained();
		configure(1'b0, 0, 2047, 4095, 0);
		repeat (2) send_item(CMD_SAMPLE, 100, -50);
		repeat (2) send_item(CMD_SAMPLE, 10, 3);
		send_item(CMD_SAMPLE, 20, 20);
		wait_drained();
		configure(1'b0, 256, 1536, 0, 1023);
		send_item(CMD_RESTORE, 0, 0);
		repeat (2) send_item(CMD_SAMPLE, 300, 0);
		wait_drained();
		configure(1'b0, 256, 1536, 32, 1);
		send_item(CMD_RESTORE, 0, 0);
		repeat (3) send_item(CMD_SAMPLE, 256, 10);
	endtask

	// long result hold so the block fills, then a stretch without idling
	task automatic test_backpressure();
		wait_drained();
		configure(1'b0, 256, 1536, 64, 4);
		send_item(CMD_RESTORE, 0, 0);
		walk_x = 0;
		walk_y = 0;
		hold_req = 60;
		send_no_gap = 1'b1;
		repeat (24) send_walk_item();
		take_no_stall = 1'b1;
		repeat (100) send_walk_item();
		send_no_gap = 1'b0;
		take_no_stall = 1'b0;
	endtask

	// random walks under several register settings
	task automatic test_random_phases();
		int mn;
		int mx;
		int n;
		for (int phase = 0; phase < 6; phase++) begin
			wait_drained();
			mn = $urandom_range(0, 1024);
			mx = $urandom_range(2047, mn);
			n = 320;
			case (phase)
				0: begin
					configure(1'b0, 256, 1536, 32, $urandom_range(1, 16));
				end
				1: begin
					configure(1'b0, 0, 2047, 4095, 0);
				end
				2: begin
					configure(1'b1, mn, mx, $urandom_range(8, 200), $urandom_range(0, 32));
				end
				3: begin
					configure(1'b0, 2047, 0, 0, 1023);
					n = 100;
				end
				default: begin
					configure(1'b0, mn, mx, $urandom_range(8, 200), $urandom_range(0, 32));
				end
			endcase
			send_item(CMD_RESTORE, 0, 0);
			walk_x = 0;
			walk_y = 0;
			repeat (n) send_walk_item();
		end
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_FREEZE;
		cfg_data      = '0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = CMD_SAMPLE;
		send_no_gap   = 1'b0;
		take_no_stall = 1'b0;
		hold_req      = 0;
		freeze_cfg    = 1'b0;
		adapt_lo_cfg  = ADAPT_LO_RST;
		adapt_hi_cfg  = ADAPT_HI_RST;
		settle_cfg    = SETTLE_RST;
		decay_cfg     = DECAY_RST;
		last_x        = 0;
		last_y        = 0;
		walk_x        = 0;
		walk_y        = 0;
		restore_words();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_register_extremes();
		test_backpressure();
		test_random_phases();

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("sent %0d items (%0d restores) over %0d register settings, %0d results checked",
			items_sent, restores_sent, settings_used, results_seen);
		$display("calibration grew %0d times and shrank %0d times, %0d steady samples",
			grow_events, shrink_events, steady_results);
		if (errors == 0)
			$display("joystick_autocal_scaler_top test passed");
		else
			$display("joystick_autocal_scaler_top test failed");
		$finish;
	end

endmodule
